### hw/rtl/tlma_pkg.sv
package tlma_pkg;

  localparam int ADC_W    = 16;
  localparam int TEMP_W   = 7;
  localparam int ENTRY_W  = 18;   // signed table entry and compare width
  localparam int IDX_W    = 9;    // widest table index (up to 512 entries)
  localparam int TEMP_MAX = 127;  // largest 7-bit temperature

  localparam logic [ADC_W-1:0] LOW_LIMIT = 16'd33587;
  localparam int TOP_ENTRY  = 58787;
  localparam int ENTRY_STEP = 280;
  localparam int BASE_TEMP  = 20;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_WRITE  = 6'b000100,
    ST_SUM    = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    ALU_CMP,  // table entry minus operand a
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Descending calibration table: entry i = 58787 - 280*i, may go negative.
  function automatic logic signed [ENTRY_W-1:0] table_entry(input logic [IDX_W-1:0] idx);
    return ENTRY_W'(TOP_ENTRY - ENTRY_STEP * int'(idx));
  endfunction

endpackage

### hw/rtl/tlma_ram.sv
module tlma_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/tlma_alu.sv
module tlma_alu #(
  parameter int W  = 18,
  parameter int IW = 7
) (
  input  tlma_pkg::alu_op_t op,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic [IW-1:0]       idx,
  output logic signed [W-1:0] res
);
  import tlma_pkg::*;

  logic signed [ENTRY_W-1:0] entry;

  assign entry = table_entry(IDX_W'(idx));

  always_comb begin
    case (op)
      ALU_CMP: res = W'(entry) - a;
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a;
    endcase
  end

endmodule

### hw/rtl/thermistor_lookup_moving_average_top.sv
// Thermistor lookup with moving average. Each transaction on the in_ channel carries one raw
// ADC reading (larger is colder). A reading above 33587 is converted to degrees F by a binary
// search of a descending calibration table (entry i = 58787 - 280*i, temperature 20 + i);
// anything at or below that limit reads as 20 F. Every temperature enters a ring of AVG_DEPTH
// entries; the first AVG_DEPTH readings produce no result, and every later reading produces one
// out_ transaction carrying the floor of the ring's mean. The block works on one reading at a
// time and holds in_ready low while busy. A reading that only fills the ring passes through the
// search, one probe per step (at most ceil(log2(TABLE_ENTRIES)) probes, 7 at the defaults), and
// the ring write; a reading that produces a result adds the ring summation, the divide by
// AVG_DEPTH (a multiply by a scaled reciprocal) and the load of the output register, and waits
// before that load only while an earlier result still holds the output register. The search
// probes and the ring summation share one adder/subtractor and run one step per cycle. The
// output register lets a result wait for out_ready while the next reading is taken.
module thermistor_lookup_moving_average_top #(
  parameter int AVG_DEPTH     = 10,
  parameter int TABLE_ENTRIES = 91
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tlma_pkg::ADC_W-1:0]  in_adc_counts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tlma_pkg::TEMP_W-1:0] out_average_temp
);
  import tlma_pkg::*;

  localparam int AW  = $clog2(AVG_DEPTH);             // ring address
  localparam int IW  = $clog2(TABLE_ENTRIES + 1);     // search bounds
  localparam int SW  = $clog2(AVG_DEPTH * TEMP_MAX + 1); // ring sum / quotient
  localparam int SEW = $clog2(AVG_DEPTH + 1);         // fill count
  localparam int CW  = $clog2(AVG_DEPTH + 1);         // summation step
  localparam int DW  = (SW + 1 > ENTRY_W) ? SW + 1 : ENTRY_W; // shared unit width
  // floor(sum / AVG_DEPTH) = (sum * RECIP) >> DIV_SH, exact for every sum below 2**SW
  localparam int DIV_SH = SW + AW;
  localparam int RECIP  = ((1 << DIV_SH) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam int MW     = SW + 2;                     // reciprocal width

  state_t             state_r, state_nxt;
  logic [ADC_W-1:0]   counts_r, counts_nxt;
  logic [IW-1:0]      lo_r, lo_nxt;
  logic [IW-1:0]      hi_r, hi_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic [SEW-1:0]     seen_r, seen_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [SW-1:0]      sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TEMP_W-1:0]  out_temp_r, out_temp_nxt;

  // Search helpers
  logic [IW:0]        mid_sum;
  logic [IW-1:0]      mid;
  logic [IW-1:0]      span;
  logic [TEMP_W-1:0]  temp;

  // Divide by the ring depth
  logic [SW+MW-1:0]   quot_prod;

  // Shared arithmetic unit
  alu_op_t            alu_op;
  logic signed [DW-1:0] alu_a, alu_b, alu_res;
  logic [IW-1:0]      alu_idx;
  logic               alu_neg;

  // Ring memory
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [TEMP_W-1:0]  ram_rdata;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[IW:1];
  assign span      = hi_r - lo_r;
  assign temp      = TEMP_W'(lo_r) + TEMP_W'(BASE_TEMP);  // wraps like the 7-bit field
  assign quot_prod = sum_r * MW'(RECIP);
  assign alu_neg   = alu_res[DW-1];
  assign ram_raddr = cnt_r[AW-1:0];

  tlma_alu #(
    .W  (DW),
    .IW (IW)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .idx (alu_idx),
    .res (alu_res)
  );

  tlma_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (temp),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    counts_nxt    = counts_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    slot_nxt      = slot_r;
    seen_nxt      = seen_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_temp_nxt  = out_temp_r;
    alu_op        = ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;
    alu_idx       = mid;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    // Drop the result once the consumer takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          counts_nxt = in_adc_counts;
          lo_nxt     = '0;
          // An over-range reading gets a one-entry search interval, so it lands on index 0
          hi_nxt     = (in_adc_counts > LOW_LIMIT) ? IW'(TABLE_ENTRIES) : IW'(1);
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (span > IW'(1)) begin
          // One probe per cycle: entry(mid) - counts < 0 means the reading is above the entry
          alu_op = ALU_CMP;
          alu_a  = DW'(counts_r);
          if (alu_neg) begin
            hi_nxt = mid;
          end else begin
            lo_nxt = mid;
          end
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we   = 1'b1;
        slot_nxt = (slot_r == AW'(AVG_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (seen_r == SEW'(AVG_DEPTH)) begin
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SUM;
        end else begin
          // Still filling the ring: no result for this reading
          seen_nxt  = seen_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        // Read slot cnt and add the data fetched in the cycle before
        ram_re = (cnt_r < CW'(AVG_DEPTH));
        alu_op = ALU_ADD;
        alu_a  = DW'(sum_r);
        alu_b  = DW'(ram_rdata);
        if (cnt_r != '0) begin
          sum_nxt = alu_res[SW-1:0];
        end
        if (cnt_r == CW'(AVG_DEPTH)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV: begin
        // Replace the sum by its quotient: multiply by the reciprocal, keep the high bits
        sum_nxt   = SW'(quot_prod[DIV_SH +: TEMP_W]);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold here until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = sum_r[TEMP_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    counts_r   <= counts_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    cnt_r      <= cnt_nxt;
    sum_r      <= sum_nxt;
    out_temp_r <= out_temp_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_average_temp = out_temp_r;

endmodule

### hw/rtl/tlma_checker.sv
module tlma_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [tlma_pkg::ADC_W-1:0]  in_adc_counts,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tlma_pkg::TEMP_W-1:0] out_average_temp
);

  // Busy after every accepted reading
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after a transaction");

  // A result never appears in the cycle right after a reading is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result rose directly after an input transaction");

  // Reset clears a pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_average_temp)))
    else $error("stalled result changed or dropped");

endmodule

bind thermistor_lookup_moving_average_top tlma_checker u_tlma_checker (.*);
